@@ hw/rtl/lhbp_pkg.sv @@
`timescale 1ns / 1ps

package lhbp_pkg;

  localparam int ADDR_W = 64;
  localparam int THR_W  = 3;

  localparam logic [THR_W-1:0] THR_RESET = 3'd3;

  localparam logic MODE_PREDICT = 1'b0;
  localparam logic MODE_UPDATE  = 1'b1;

  typedef struct packed {
    logic clear_step;
    logic load_item;
    logic read_hist;
    logic read_cnt;
    logic write_back;
    logic load_out;
  } lhbp_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic is_update;
    logic out_free;
  } lhbp_status_t;

endpackage

@@ hw/rtl/lhbp_if.sv @@
`timescale 1ns / 1ps

interface lhbp_req_if;
  logic                       valid;
  logic                       ready;
  logic                       mode;
  logic [lhbp_pkg::ADDR_W-1:0] branch_address;
  logic                       outcome_taken;

  modport source (output valid, output mode, output branch_address, output outcome_taken,
                  input ready);
  modport sink (input valid, input mode, input branch_address, input outcome_taken,
                output ready);
endinterface

interface lhbp_rsp_if;
  logic valid;
  logic ready;
  logic predict_taken;

  modport source (output valid, output predict_taken, input ready);
  modport sink (input valid, input predict_taken, output ready);
endinterface

interface lhbp_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [lhbp_pkg::THR_W-1:0] taken_threshold;

  modport source (output valid, output taken_threshold, input ready);
  modport sink (input valid, input taken_threshold, output ready);
endinterface

@@ hw/rtl/lhbp_ctrl.sv @@
`timescale 1ns / 1ps

module lhbp_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   req_valid,
  output logic                   req_ready,
  input  lhbp_pkg::lhbp_status_t status,
  output lhbp_pkg::lhbp_cmd_t    cmd
);
  import lhbp_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD_HIST,
    ST_RD_CNT,
    ST_EXEC
  } state_t;

  state_t state;
  logic   accept;
  logic   exec_done;

  assign accept    = req_valid && req_ready;
  assign exec_done = status.is_update || status.out_free;

  always_comb begin
    cmd            = '0;
    cmd.clear_step = (state == ST_CLEAR);
    cmd.load_item  = accept;
    cmd.read_hist  = (state == ST_RD_HIST);
    cmd.read_cnt   = (state == ST_RD_CNT);
    cmd.write_back = (state == ST_EXEC) && status.is_update;
    cmd.load_out   = (state == ST_EXEC) && !status.is_update && status.out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      req_ready <= 1'b0;
    end else begin
      unique case (state)
        ST_CLEAR: begin
          if (status.clear_done) begin
            state     <= ST_IDLE;
            req_ready <= 1'b1;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            state     <= ST_RD_HIST;
            req_ready <= 1'b0;
          end
        end
        ST_RD_HIST: begin
          state <= ST_RD_CNT;
        end
        ST_RD_CNT: begin
          state <= ST_EXEC;
        end
        ST_EXEC: begin
          if (exec_done) begin
            state     <= ST_IDLE;
            req_ready <= 1'b1;
          end
        end
        default: begin
          state     <= ST_CLEAR;
          req_ready <= 1'b0;
        end
      endcase
    end
  end

endmodule

@@ hw/rtl/lhbp_datapath.sv @@
`timescale 1ns / 1ps

module lhbp_datapath #(
  parameter int HIST_LEN           = 8,
  parameter int HIST_INDEX_BITS    = 18,
  parameter int COUNTER_INDEX_BITS = 20,
  parameter int COUNTER_WIDTH      = 3
) (
  input  logic                         clk,
  input  logic                         rst,
  input  lhbp_pkg::lhbp_cmd_t          cmd,
  output lhbp_pkg::lhbp_status_t       status,
  input  logic                         mode,
  input  logic [lhbp_pkg::ADDR_W-1:0]  branch_address,
  input  logic                         outcome_taken,
  output logic                         rsp_valid,
  input  logic                         rsp_ready,
  output logic                         predict_taken,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [lhbp_pkg::THR_W-1:0]   taken_threshold
);
  import lhbp_pkg::*;

  localparam int CLR_W = (HIST_INDEX_BITS > COUNTER_INDEX_BITS) ?
                         HIST_INDEX_BITS : COUNTER_INDEX_BITS;
  localparam int CMP_W = (COUNTER_WIDTH > THR_W) ? COUNTER_WIDTH : THR_W;

  logic [HIST_LEN-1:0]      hist_mem [2**HIST_INDEX_BITS];
  logic [COUNTER_WIDTH-1:0] cnt_mem  [2**COUNTER_INDEX_BITS];

  logic                          item_mode;
  logic                          item_taken;
  logic [CLR_W-1:0]              item_addr;
  logic [HIST_LEN-1:0]           hist_q;
  logic [COUNTER_WIDTH-1:0]      cnt_q;
  logic [CLR_W-1:0]              clr_idx;
  logic [THR_W-1:0]              threshold;

  logic [HIST_INDEX_BITS-1:0]    hslot;
  logic [COUNTER_INDEX_BITS-1:0] cidx;
  logic [HIST_LEN:0]             hist_shift;
  logic [HIST_LEN-1:0]           hist_next;
  logic [COUNTER_WIDTH-1:0]      cnt_next;
  logic                          pred;

  assign hslot      = item_addr[HIST_INDEX_BITS-1:0];
  assign hist_shift = {hist_q, item_taken};
  assign hist_next  = hist_shift[HIST_LEN-1:0];

  generate
    if (HIST_LEN >= COUNTER_INDEX_BITS) begin : g_hist_only
      assign cidx = hist_q[COUNTER_INDEX_BITS-1:0];
    end else begin : g_addr_hist
      assign cidx = {item_addr[COUNTER_INDEX_BITS-HIST_LEN-1:0], hist_q};
    end
  endgenerate

  always_comb begin
    if (item_taken) begin
      cnt_next = (cnt_q == '1) ? cnt_q : cnt_q + COUNTER_WIDTH'(1);
    end else begin
      cnt_next = (cnt_q == '0) ? cnt_q : cnt_q - COUNTER_WIDTH'(1);
    end
  end

  assign pred = (CMP_W'(cnt_q) >= CMP_W'(threshold));

  always_ff @(posedge clk) begin
    if (cmd.clear_step) begin
      hist_mem[clr_idx[HIST_INDEX_BITS-1:0]] <= '0;
    end else if (cmd.write_back) begin
      hist_mem[hslot] <= hist_next;
    end
    if (cmd.read_hist) begin
      hist_q <= hist_mem[hslot];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clear_step) begin
      cnt_mem[clr_idx[COUNTER_INDEX_BITS-1:0]] <= '0;
    end else if (cmd.write_back) begin
      cnt_mem[cidx] <= cnt_next;
    end
    if (cmd.read_cnt) begin
      cnt_q <= cnt_mem[cidx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_mode  <= mode;
      item_taken <= outcome_taken;
      item_addr  <= branch_address[CLR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
    end else if (cmd.clear_step) begin
      clr_idx <= clr_idx + CLR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THR_RESET;
    end else if (cfg_valid) begin
      threshold <= taken_threshold;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.load_out) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      predict_taken <= pred;
    end
  end

  assign cfg_ready         = 1'b1;
  assign status.clear_done = (clr_idx == '1);
  assign status.is_update  = (item_mode == MODE_UPDATE);
  assign status.out_free   = !rsp_valid || rsp_ready;

endmodule

@@ hw/rtl/local_history_branch_predictor_top.sv @@
`timescale 1ns / 1ps

// Two-level local-history branch predictor.
// req: one transaction per branch; mode selects predict or update,
//   branch_address names the branch, outcome_taken is the resolved direction.
// rsp: one transaction with predict_taken for every predict request; updates
//   give none. Results leave in request order through an output register.
// cfg: writes taken_threshold; always ready, write only while idle.
// Timing: a request is accepted when ready is high, then the history memory
//   read, the counter memory read and the execute step follow in turn, and
//   ready returns once execute completes. The prediction is visible on rsp
//   the cycle after execute. A new request is not taken until the previous
//   one has left execute, as the counter read depends on the history read.
// Stall: a result held in rsp does not block the next request; only a
//   prediction that finds rsp still full waits in execute.
// Reset: rst clears both tables with a sweep of 2^max(HIST_INDEX_BITS,
//   COUNTER_INDEX_BITS) entries (1048576 by default) during which req.ready is
//   low; cfg writes are taken during the sweep. taken_threshold resets to 3.
module local_history_branch_predictor_top #(
  parameter int HIST_LEN           = 8,
  parameter int HIST_INDEX_BITS    = 18,
  parameter int COUNTER_INDEX_BITS = 20,
  parameter int COUNTER_WIDTH      = 3
) (
  input  logic        clk,
  input  logic        rst,
  lhbp_req_if.sink    req,
  lhbp_rsp_if.source  rsp,
  lhbp_cfg_if.sink    cfg
);
  import lhbp_pkg::*;

  lhbp_cmd_t    cmd;
  lhbp_status_t status;

  lhbp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .status    (status),
    .cmd       (cmd)
  );

  lhbp_datapath #(
    .HIST_LEN           (HIST_LEN),
    .HIST_INDEX_BITS    (HIST_INDEX_BITS),
    .COUNTER_INDEX_BITS (COUNTER_INDEX_BITS),
    .COUNTER_WIDTH      (COUNTER_WIDTH)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .mode            (req.mode),
    .branch_address  (req.branch_address),
    .outcome_taken   (req.outcome_taken),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .predict_taken   (rsp.predict_taken),
    .cfg_valid       (cfg.valid),
    .cfg_ready       (cfg.ready),
    .taken_threshold (cfg.taken_threshold)
  );

endmodule

@@ hw/rtl/lhbp_checker.sv @@
`timescale 1ns / 1ps

module lhbp_checker (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input logic rsp_valid,
  input logic rsp_ready,
  input logic rsp_predict_taken,
  input logic cfg_ready
);

  // one request in flight at a time
  a_req_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("request accepted while previous transaction in flight");

  // a new result follows its request through the history read, counter read and execute states
  a_rsp_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(req_valid && req_ready, 4))
    else $error("result without matching request");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_predict_taken)))
    else $error("stalled result dropped or changed");

  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_ready)
    else $error("configuration channel not ready");

endmodule

bind local_history_branch_predictor_top lhbp_checker u_lhbp_checker (
  .clk               (clk),
  .rst               (rst),
  .req_valid         (req.valid),
  .req_ready         (req.ready),
  .rsp_valid         (rsp.valid),
  .rsp_ready         (rsp.ready),
  .rsp_predict_taken (rsp.predict_taken),
  .cfg_ready         (cfg.ready)
);

@@ test/lhbp_checker.sv @@
`timescale 1ns / 1ps

module tb_lhbp_checker #(
  parameter int HIST_LEN           = 8,
  parameter int HIST_INDEX_BITS    = 18,
  parameter int COUNTER_INDEX_BITS = 20,
  parameter int COUNTER_WIDTH      = 3
) (
  input  logic clk,
  input  logic rst,
  lhbp_req_if  req,
  lhbp_rsp_if  rsp,
  lhbp_cfg_if  cfg,
  output int   mismatches,
  output int   outstanding
);

  import lhbp_pkg::*;

  localparam int HIST_ENTRIES   = 1 << HIST_INDEX_BITS;
  localparam int CNT_ENTRIES    = 1 << COUNTER_INDEX_BITS;
  localparam int ADDR_PART_BITS =
    (COUNTER_INDEX_BITS > HIST_LEN) ? (COUNTER_INDEX_BITS - HIST_LEN) : 0;
  localparam bit [COUNTER_WIDTH-1:0] CNT_MAX = '1;

  bit [HIST_LEN-1:0]      history_tab [HIST_ENTRIES];
  bit [COUNTER_WIDTH-1:0] counter_tab [CNT_ENTRIES];
  logic [THR_W-1:0]       threshold = THR_RESET;
  bit                     expected_dir [$];

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  function automatic int unsigned history_slot(input logic [ADDR_W-1:0] addr);
    logic [63:0] slot;
    slot = 64'(addr) & (64'(HIST_ENTRIES) - 64'd1);
    return slot[31:0];
  endfunction

  function automatic int unsigned counter_slot(input logic [ADDR_W-1:0] addr,
                                               input bit [HIST_LEN-1:0] hist);
    logic [63:0] part;
    logic [63:0] slot;
    part = 64'(addr) & ((64'd1 << ADDR_PART_BITS) - 64'd1);
    slot = ((part << HIST_LEN) | 64'(hist)) & (64'(CNT_ENTRIES) - 64'd1);
    return slot[31:0];
  endfunction

  task automatic flag_mismatch(input string what, input logic got, input logic want);
    $display("%0t mismatch: %s got %b want %b", $time, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin : track
    int unsigned            hs;
    int unsigned            cs;
    bit [HIST_LEN-1:0]      h;
    bit [HIST_LEN:0]        shifted;
    bit [COUNTER_WIDTH-1:0] c;
    bit                     want;
    if (!rst) begin
      if (cfg.valid && cfg.ready)
        threshold = cfg.taken_threshold;
      if (req.valid && req.ready) begin
        hs = history_slot(req.branch_address);
        h  = history_tab[hs];
        cs = counter_slot(req.branch_address, h);
        c  = counter_tab[cs];
        if (req.mode == MODE_PREDICT) begin
          expected_dir.push_back(c >= threshold);
        end else begin
          shifted = {h, req.outcome_taken};
          history_tab[hs] = shifted[HIST_LEN-1:0];
          if (req.outcome_taken) begin
            if (c != CNT_MAX)
              c++;
          end else if (c != 0) begin
            c--;
          end
          counter_tab[cs] = c;
        end
      end
      if (rsp.valid && rsp.ready) begin
        if (expected_dir.size() == 0) begin
          flag_mismatch("prediction with none pending", rsp.predict_taken, 1'bx);
        end else begin
          want = expected_dir.pop_front();
          if (rsp.predict_taken !== want)
            flag_mismatch("predict_taken", rsp.predict_taken, want);
        end
      end
    end
    outstanding <= expected_dir.size();
  end

endmodule

@@ test/tb_local_history_branch_predictor_top.sv @@
`timescale 1ns / 1ps

module tb_local_history_branch_predictor_top;

  import lhbp_pkg::*;

  localparam int P_HIST_LEN           = 8;
  localparam int P_HIST_INDEX_BITS    = 18;
  localparam int P_COUNTER_INDEX_BITS = 20;
  localparam int P_COUNTER_WIDTH      = 3;

  localparam int WATCHDOG_LIMIT  = 3_500_000;
  localparam int SETTLE_CYCLES   = 16;
  localparam int LONG_HOLD       = 400;
  localparam int RANDOM_PHASES   = 6;
  localparam int PHASE_ITEMS     = 272;
  localparam int POOL_SIZE       = 12;

  logic clk = 1'b0;
  logic rst = 1'b1;

  lhbp_req_if req ();
  lhbp_rsp_if rsp ();
  lhbp_cfg_if cfg ();

  int mismatches;
  int outstanding;
  int idle_cycles = 0;
  bit stress_go   = 1'b0;

  always #4 clk = ~clk;

  local_history_branch_predictor_top #(
    .HIST_LEN           (P_HIST_LEN),
    .HIST_INDEX_BITS    (P_HIST_INDEX_BITS),
    .COUNTER_INDEX_BITS (P_COUNTER_INDEX_BITS),
    .COUNTER_WIDTH      (P_COUNTER_WIDTH)
  ) dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp),
    .cfg (cfg)
  );

  tb_lhbp_checker #(
    .HIST_LEN           (P_HIST_LEN),
    .HIST_INDEX_BITS    (P_HIST_INDEX_BITS),
    .COUNTER_INDEX_BITS (P_COUNTER_INDEX_BITS),
    .COUNTER_WIDTH      (P_COUNTER_WIDTH)
  ) u_check (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .rsp         (rsp),
    .cfg         (cfg),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always @(posedge clk) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic offer(input logic m, input logic [ADDR_W-1:0] a, input logic t);
    req.valid          <= 1'b1;
    req.mode           <= m;
    req.branch_address <= a;
    req.outcome_taken  <= t;
    do @(posedge clk); while (req.ready !== 1'b1);
  endtask

  task automatic load_threshold(input logic [THR_W-1:0] v);
    cfg.valid           <= 1'b1;
    cfg.taken_threshold <= v;
    do @(posedge clk); while (cfg.ready !== 1'b1);
    cfg.valid <= 1'b0;
  endtask

  task automatic settle_block();
    req.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // receiver: random ready patterns, rare holds, one long hold to back up the block
  initial begin : sink_side
    int  span;
    int  style;
    bit  long_hold_done;
    long_hold_done = 1'b0;
    rsp.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (stress_go && !long_hold_done) begin
        long_hold_done = 1'b1;
        rsp.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      span  = $urandom_range(8, 64);
      style = $urandom_range(0, 3);
      repeat (span) begin
        case (style)
          0: begin
            rsp.ready <= 1'b1;
          end
          1: begin
            rsp.ready <= 1'($urandom_range(0, 1));
          end
          2: begin
            rsp.ready <= ($urandom_range(0, 4) == 0);
          end
          default: begin
            rsp.ready <= ($urandom_range(0, 19) != 0);
          end
        endcase
        @(posedge clk);
      end
      if ($urandom_range(0, 49) == 0) begin
        rsp.ready <= 1'b0;
        repeat ($urandom_range(40, 150)) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    logic [ADDR_W-1:0] addr_a;
    logic [ADDR_W-1:0] addr_b;
    logic [ADDR_W-1:0] branch_pool [POOL_SIZE];
    int                taken_bias [POOL_SIZE];
    logic [THR_W-1:0]  phase_thr [RANDOM_PHASES];
    logic [ADDR_W-1:0] a;
    logic              m;
    logic              t;
    int                k;
    int                burst_left;
    int                gap;

    req.valid           <= 1'b0;
    req.mode            <= MODE_PREDICT;
    req.branch_address  <= '0;
    req.outcome_taken   <= 1'b0;
    cfg.valid           <= 1'b0;
    cfg.taken_threshold <= '0;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    addr_a = 64'h5555_aaaa_0000_0123;
    addr_b = 64'haaaa_5555_ffff_fedc;

    // reset threshold: cold tables, floor saturation, history fill
    offer(MODE_PREDICT, '0, 1'b0);
    offer(MODE_PREDICT, '1, 1'b1);
    offer(MODE_UPDATE, '1, 1'b0);
    offer(MODE_PREDICT, '1, 1'b0);
    repeat (10) offer(MODE_UPDATE, addr_a, 1'b1);
    offer(MODE_PREDICT, addr_a, 1'b0);
    offer(MODE_UPDATE, addr_b, 1'b0);
    offer(MODE_PREDICT, addr_b, 1'b1);
    settle_block();

    // threshold zero: always taken
    load_threshold(3'd0);
    offer(MODE_PREDICT, '0, 1'b0);
    offer(MODE_PREDICT, '1, 1'b1);
    offer(MODE_PREDICT, addr_a, 1'b0);
    settle_block();

    // threshold at counter maximum
    load_threshold(3'd7);
    offer(MODE_PREDICT, addr_a, 1'b1);
    offer(MODE_PREDICT, 64'h8000_0000_0000_0000, 1'b0);
    offer(MODE_UPDATE, addr_a, 1'b1);
    offer(MODE_PREDICT, addr_a, 1'b0);
    settle_block();

    phase_thr[0] = 3'd2;
    phase_thr[1] = 3'd7;
    phase_thr[2] = 3'd0;
    for (int p = 3; p < RANDOM_PHASES; p++)
      phase_thr[p] = THR_W'($urandom_range(0, 7));

    burst_left = 0;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      load_threshold(phase_thr[ph]);
      for (int j = 0; j < POOL_SIZE; j++) begin
        branch_pool[j] = {$urandom, $urandom};
        if (j % 2 == 1)
          branch_pool[j][11:0] = branch_pool[j-1][11:0];
        case ($urandom_range(0, 5))
          0:       taken_bias[j] = 0;
          1:       taken_bias[j] = 3;
          2:       taken_bias[j] = 50;
          3:       taken_bias[j] = 97;
          4:       taken_bias[j] = 100;
          default: taken_bias[j] = $urandom_range(0, 100);
        endcase
      end
      stress_go = 1'b1;
      repeat (PHASE_ITEMS) begin
        if ($urandom_range(0, 99) < 80) begin
          k = $urandom_range(0, POOL_SIZE - 1);
          a = branch_pool[k];
          if ($urandom_range(0, 1))
            a[ADDR_W-1:P_HIST_INDEX_BITS] =
              (ADDR_W - P_HIST_INDEX_BITS)'({$urandom, $urandom});
          m = ($urandom_range(0, 99) < 55) ? MODE_UPDATE : MODE_PREDICT;
          t = (m == MODE_UPDATE) ? ($urandom_range(0, 99) < taken_bias[k]) :
                                   1'($urandom_range(0, 1));
        end else begin
          a = {$urandom, $urandom};
          m = $urandom_range(0, 1) ? MODE_UPDATE : MODE_PREDICT;
          t = 1'($urandom_range(0, 1));
        end
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          if (gap > 0) begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
          end
        end
        burst_left--;
        offer(m, a, t);
      end
      settle_block();
    end

    if (mismatches == 0 && outstanding == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ local_history_branch_predictor_top.f @@
hw/rtl/lhbp_pkg.sv
hw/rtl/lhbp_if.sv
hw/rtl/lhbp_ctrl.sv
hw/rtl/lhbp_datapath.sv
hw/rtl/local_history_branch_predictor_top.sv
hw/rtl/lhbp_checker.sv
test/lhbp_checker.sv
test/tb_local_history_branch_predictor_top.sv
